// File: sv/s88m_pkg.sv
`default_nettype none
package s88m_pkg;

  // Largest number of 8-input groups the stores are built for
  localparam int MAX_GROUPS = 32;

  localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
  localparam int BYTE_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int BC_W   = $clog2(MAX_GROUPS * 8 + 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_GROUP_COUNT   = 2'd0;
  localparam logic [1:0] CFG_HALF_CLOCK    = 2'd1;
  localparam logic [1:0] CFG_CONTROL_PULSE = 2'd2;
  localparam logic [1:0] CFG_SCAN_INTERVAL = 2'd3;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_PRE   = 4'd1;
  localparam logic [3:0] PH_LOAD  = 4'd2;
  localparam logic [3:0] PH_C0H   = 4'd3;
  localparam logic [3:0] PH_C0L   = 4'd4;
  localparam logic [3:0] PH_RSTH  = 4'd5;
  localparam logic [3:0] PH_RSTL  = 4'd6;
  localparam logic [3:0] PH_LOADL = 4'd7;
  localparam logic [3:0] PH_BH    = 4'd8;
  localparam logic [3:0] PH_BL    = 4'd9;

  typedef struct packed {
    logic [5:0]  group_count;
    logic [15:0] half_clock_ticks;
    logic [15:0] control_pulse_ticks;
    logic [23:0] scan_interval_ticks;
  } cfg_t;

  typedef struct packed {
    logic       clock_out;
    logic       load_out;
    logic       reset_out;
    logic       busy_res;
    logic       scan_done;
    logic [7:0] read_data;
  } res_t;

endpackage
`default_nettype wire

// File: sv/s88m_seq.sv
`default_nettype none
module s88m_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic          mode,
  input  wire logic          data_in,
  input  wire logic [4:0]    read_index,
  input  wire s88m_pkg::cfg_t cfg,
  output s88m_pkg::res_t     res
);
  import s88m_pkg::*;

  logic [3:0]       phase_r, phase_nxt;
  logic [15:0]      ptimer_r, ptimer_nxt;
  logic [BC_W-1:0]  bitcnt_r, bitcnt_nxt;
  logic [23:0]      itimer_r, itimer_nxt;
  logic [7:0]       capture_r  [MAX_GROUPS];
  logic [7:0]       capture_nxt[MAX_GROUPS];
  logic [7:0]       snap_r     [MAX_GROUPS];
  logic [7:0]       snap_nxt   [MAX_GROUPS];

  logic [CNT_W-1:0] count;
  logic [23:0]      it_inc;
  logic             start;
  logic [3:0]       ph_cur, line_ph;
  logic [15:0]      pt_cur, dur;
  logic [16:0]      pt_sum;
  logic [BC_W-1:0]  bc_cur, bc_inc;
  logic             expire, sample, last, done;

  always_comb begin
    // group count clamped to 1..MAX_GROUPS
    if (cfg.group_count == 6'd0) begin
      count = CNT_W'(1);
    end else if (CNT_W'(cfg.group_count) > CNT_W'(MAX_GROUPS) ||
                 32'(cfg.group_count) > MAX_GROUPS) begin
      count = CNT_W'(MAX_GROUPS);
    end else begin
      count = CNT_W'(cfg.group_count);
    end

    it_inc = (itimer_r == '1) ? itimer_r : itimer_r + 24'd1;
    start  = (phase_r == PH_IDLE) && (it_inc >= cfg.scan_interval_ticks);

    ph_cur = start ? PH_PRE : phase_r;
    pt_cur = start ? 16'd0 : ptimer_r;
    bc_cur = start ? '0 : bitcnt_r;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      capture_nxt[i] = start ? 8'd0 : capture_r[i];
    end

    dur = (ph_cur == PH_C0H || ph_cur == PH_C0L || ph_cur == PH_BH || ph_cur == PH_BL) ?
          cfg.half_clock_ticks : cfg.control_pulse_ticks;
    pt_sum = {1'b0, pt_cur} + 17'd1;
    expire = (ph_cur != PH_IDLE) && (pt_sum >= {1'b0, dur});
    sample = expire && (ph_cur == PH_C0L || ph_cur == PH_BL);
    bc_inc = bc_cur + BC_W'(1);

    for (int i = 0; i < MAX_GROUPS; i++) begin
      if (sample && data_in && (32'(bc_cur[BC_W-1:3]) == i)) begin
        capture_nxt[i][bc_cur[2:0]] = 1'b1;
      end
    end

    last = (32'(bc_inc) >= 32'(count) * 8);
    done = expire && (ph_cur == PH_BL) && last;

    // phase advance
    phase_nxt = ph_cur;
    if (expire) begin
      case (ph_cur)
        PH_PRE:   phase_nxt = PH_LOAD;
        PH_LOAD:  phase_nxt = PH_C0H;
        PH_C0H:   phase_nxt = PH_C0L;
        PH_C0L:   phase_nxt = PH_RSTH;
        PH_RSTH:  phase_nxt = PH_RSTL;
        PH_RSTL:  phase_nxt = PH_LOADL;
        PH_LOADL: phase_nxt = PH_BH;
        PH_BH:    phase_nxt = PH_BL;
        PH_BL:    phase_nxt = last ? PH_IDLE : PH_BH;
        default:  phase_nxt = PH_IDLE;
      endcase
    end

    ptimer_nxt = (ph_cur == PH_IDLE) ? pt_cur : (expire ? 16'd0 : pt_sum[15:0]);
    bitcnt_nxt = sample ? bc_inc : bc_cur;
    itimer_nxt = start ? 24'd0 : it_inc;

    for (int i = 0; i < MAX_GROUPS; i++) begin
      snap_nxt[i] = snap_r[i];
      if (done) begin
        snap_nxt[i] = (i < 32'(count)) ? capture_nxt[i] : 8'd0;
      end
    end

    // result word
    line_ph       = mode ? phase_r : ph_cur;
    res.clock_out = (line_ph == PH_C0H) || (line_ph == PH_BH);
    res.load_out  = (line_ph == PH_LOAD) || (line_ph == PH_C0H) || (line_ph == PH_C0L) ||
                    (line_ph == PH_RSTH) || (line_ph == PH_RSTL);
    res.reset_out = (line_ph == PH_RSTH);
    res.busy_res  = (line_ph != PH_IDLE);
    res.scan_done = !mode && done;
    res.read_data = (mode && (32'(read_index) < 32'(count))) ?
                    snap_r[BYTE_W'(read_index)] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      ptimer_r <= 16'd0;
      bitcnt_r <= '0;
      itimer_r <= 24'd0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        capture_r[i] <= 8'd0;
        snap_r[i]    <= 8'd0;
      end
    end else if (accept && !mode) begin
      phase_r  <= phase_nxt;
      ptimer_r <= ptimer_nxt;
      bitcnt_r <= bitcnt_nxt;
      itimer_r <= itimer_nxt;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        capture_r[i] <= capture_nxt[i];
        snap_r[i]    <= snap_nxt[i];
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/s88m_out.sv
`default_nettype none
module s88m_out (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire s88m_pkg::res_t res,
  output logic                out_valid,
  input  wire logic           out_stall,
  output s88m_pkg::res_t      out_res,
  output logic                accept
);
  import s88m_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  // take a new word whenever the result register is empty or draining
  assign in_stall  = valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign valid_nxt = accept || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

// File: sv/s88_bus_scan_master.sv
`default_nettype none
// channel | direction | handshake           | payload
// in      | in        | in_valid / in_stall | in_mode, in_data_in, in_read_index
// out     | out       | out_valid/out_stall | out_clock_out .. out_read_data
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word per cycle in while in_stall is low, one result word per word, registered.
// The sequencer state and the result register both sit behind a single pass of logic.
// rst_n (synchronous) clears the sequencer, the capture and snapshot stores,
// and loads the config defaults.
// The in channel stalls only while a result waits and out_stall is high.
// cfg_ready is always high.
module s88_bus_scan_master (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic        in_data_in,
  input  wire logic [4:0]  in_read_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_clock_out,
  output logic             out_load_out,
  output logic             out_reset_out,
  output logic             out_busy_res,
  output logic             out_scan_done,
  output logic [7:0]       out_read_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import s88m_pkg::*;

  cfg_t cfg_r;
  res_t res, out_res;
  logic accept;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.group_count         <= 6'd2;
      cfg_r.half_clock_ticks    <= 16'd50;
      cfg_r.control_pulse_ticks <= 16'd10;
      cfg_r.scan_interval_ticks <= 24'd20000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GROUP_COUNT:   cfg_r.group_count         <= cfg_data[5:0];
        CFG_HALF_CLOCK:    cfg_r.half_clock_ticks    <= cfg_data[15:0];
        CFG_CONTROL_PULSE: cfg_r.control_pulse_ticks <= cfg_data[15:0];
        CFG_SCAN_INTERVAL: cfg_r.scan_interval_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // bus sequencer, capture and snapshot stores
  s88m_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .mode       (in_mode),
    .data_in    (in_data_in),
    .read_index (in_read_index),
    .cfg        (cfg_r),
    .res        (res)
  );

  // result register
  s88m_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .accept    (accept)
  );

  assign out_clock_out = out_res.clock_out;
  assign out_load_out  = out_res.load_out;
  assign out_reset_out = out_res.reset_out;
  assign out_busy_res  = out_res.busy_res;
  assign out_scan_done = out_res.scan_done;
  assign out_read_data = out_res.read_data;

endmodule
`default_nettype wire

// File: sv/s88m_chk.sv
`default_nettype none
module s88m_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_clock_out,
  input wire logic       out_load_out,
  input wire logic       out_reset_out,
  input wire logic       out_busy_res,
  input wire logic       out_scan_done,
  input wire logic [7:0] out_read_data
);

  // a stalled result word stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // snapshot published only while a scan is under way
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scan_done |-> out_busy_res)
    else $error("scan_done without busy");

  // read data and scan_done never come in the same word
  a_done_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scan_done |-> (out_read_data == 8'd0))
    else $error("read data on a tick word");

  // RESET pulse only with LOAD high and clock low
  a_reset_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reset_out |-> out_load_out && !out_clock_out && out_busy_res)
    else $error("RESET line outside its phase");

endmodule

bind s88_bus_scan_master s88m_chk u_chk (.*);
`default_nettype wire
